@@ hdl/assert_macros.svh @@
// Assertion macros used by the checker of this project.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define CHK_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("check failed");
// Next-cycle implication outside reset.
`define CHK_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("check failed");
`endif

@@ hdl/tsat_pkg.sv @@
// Package for the 2-SAT component solver: state codes, error codes and fixed widths.
// Depends on nothing.
package tsat_pkg;
  localparam int unsigned MaxVars = 64;
  localparam int unsigned VarW = 6;
  localparam int unsigned CfgW = 7;
  localparam int unsigned ErrW = 2;
  localparam logic [ErrW-1:0] ErrNone = 2'd0;
  localparam logic [ErrW-1:0] ErrFull = 2'd1;
  localparam logic [ErrW-1:0] ErrVar  = 2'd2;
  localparam int unsigned StW = 4;
  localparam logic [StW-1:0] StLoad   = 4'd0;
  localparam logic [StW-1:0] StCheck  = 4'd1;
  localparam logic [StW-1:0] StClr    = 4'd2;
  localparam logic [StW-1:0] StRoot   = 4'd3;
  localparam logic [StW-1:0] StScan   = 4'd4;
  localparam logic [StW-1:0] StPop    = 4'd5;
  localparam logic [StW-1:0] StCmp    = 4'd6;
  localparam logic [StW-1:0] StOut    = 4'd7;
  localparam logic [StW-1:0] StRd     = 4'd8;
  localparam logic [StW-1:0] StRdWait = 4'd9;
  localparam logic [StW-1:0] StTop    = 4'd10;
  localparam logic [StW-1:0] StCmpB   = 4'd11;
  localparam logic [StW-1:0] StPopRd  = 4'd12;
  localparam logic [StW-1:0] StPopTop = 4'd13;
endpackage

@@ hdl/two_sat_scc_solver_top.sv @@
// Top level of the 2-SAT solver: clause store, Kosaraju walk sequencer.
// Depends on tsat_pkg.
//
// Channel | Direction | Payload
// s_axis  | in        | clause: literals a and b, tlast marks the final clause
// m_axis  | out       | one result per problem: satisfiable, error code
// cfg     | in        | var_count register
//
// Clauses load one per cycle while no result is pending. The tlast clause starts
// the solve, and the block is not ready again until its result is taken. With C
// clauses and N variables the solve runs a range check over the stored clauses,
// then depth-first passes that scan up to 2*C edge slots per node (4*N*C per pass)
// with push, pop and root-pick steps, then a label compare per variable.
// Reset is synchronous and active high; a stalled result holds in its register.
module two_sat_scc_solver_top #(
  parameter int unsigned MAX_CLAUSES = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [5:0] lit_a_var, [6] lit_a_neg, [12:7] lit_b_var, [13] lit_b_neg, [15:14] zero
  input  logic [15:0] s_axis_tdata,
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] satisfiable, [2:1] error_code, [7:3] zero
  output logic [7:0]  m_axis_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [tsat_pkg::CfgW-1:0] cfg_data
);
  import tsat_pkg::*;

  localparam int unsigned LitN = 2 * MaxVars;
  localparam int unsigned LW   = $clog2(LitN);
  localparam int unsigned CW   = $clog2(MAX_CLAUSES);
  localparam int unsigned TW   = $clog2(MAX_CLAUSES + 1);
  localparam int unsigned SW   = TW + 1;         // edge slot cursor, 0..2*C+1
  localparam int unsigned DW   = $clog2(LitN + 1);
  localparam int unsigned NW   = $clog2(MaxVars + 1);

  // Memories.
  logic [2*LW-1:0] cmem [MAX_CLAUSES];
  logic [2*LW-1:0] crd;
  logic [LW-1:0]   stk_node [LitN];
  logic [SW-1:0]   stk_cur  [LitN];
  logic [LW-1:0]   ford     [LitN];
  logic [LW-1:0]   lab      [LitN];
  logic [LW-1:0]   rd_node, ford_rd, lab_rd;
  logic [SW-1:0]   rd_cur;
  logic [LitN-1:0] vis;

  logic [StW-1:0] state;
  logic [CfgW-1:0] var_count;
  logic [TW-1:0]  total;
  logic [ErrW-1:0] err;
  logic [SW-1:0]  cur;
  logic [LW-1:0]  node;
  logic [DW-1:0]  depth, olen, k;
  logic           rev;
  logic [LW-1:0]  label;
  logic           sat;
  logic [LW-1:0]  lab_a;
  logic [NW-1:0]  nvar;

  assign nvar = (var_count > CfgW'(MaxVars)) ? NW'(MaxVars) : NW'(var_count);

  logic [VarW-1:0] av, bv;
  logic an, bn;
  assign av = s_axis_tdata[5:0];
  assign an = s_axis_tdata[6];
  assign bv = s_axis_tdata[12:7];
  assign bn = s_axis_tdata[13];

  assign s_axis_tready = (state == StLoad) && !m_axis_tvalid;
  assign cfg_ready     = 1'b1;

  // Edge decode for the slot just read.
  logic [LW-1:0] la, lb, nbr;
  logic hit, side;
  assign la = crd[2*LW-1:LW];
  assign lb = crd[LW-1:0];
  always_comb begin
    hit = 1'b0;
    nbr = lb;
    if (!rev) begin
      if (!side && node == (la ^ LW'(1))) begin hit = 1'b1; nbr = lb; end
      if (side && node == (lb ^ LW'(1))) begin hit = 1'b1; nbr = la; end
    end else begin
      if (!side && node == lb) begin hit = 1'b1; nbr = la ^ LW'(1); end
      if (side && node == la) begin hit = 1'b1; nbr = lb ^ LW'(1); end
    end
  end

  logic [SW-1:0] slots;
  assign slots = {total, 1'b0};
  logic [CW-1:0] raddr;
  always_comb begin
    raddr = cur[CW:1];
    if (state == StCheck) raddr = cur[CW-1:0];
  end

  // Memory ports.
  logic          cm_we;
  logic [CW-1:0] cm_wa;
  assign cm_we = s_axis_tvalid && s_axis_tready && (av < nvar) && (bv < nvar)
                 && (total < TW'(MAX_CLAUSES));
  assign cm_wa = total[CW-1:0];
  always_ff @(posedge clk) begin
    if (cm_we) cmem[cm_wa] <= {LW'({av, an}), LW'({bv, bn})};
    crd <= cmem[raddr];
  end

  logic side_q;
  assign side = side_q;

  always_ff @(posedge clk) begin
    rd_node <= stk_node[depth[LW-1:0] - LW'(1)];
    rd_cur  <= stk_cur[depth[LW-1:0] - LW'(1)];
    ford_rd <= ford[k[LW-1:0] - LW'(1)];
    lab_rd  <= lab[k[LW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= StLoad; var_count <= CfgW'(MaxVars); total <= '0; err <= ErrNone;
      m_axis_tvalid <= 1'b0; vis <= '0; depth <= '0; cur <= '0; rev <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) var_count <= cfg_data;
      if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
      case (state)
        StLoad: begin
          if (s_axis_tvalid && s_axis_tready) begin
            if (av >= nvar || bv >= nvar) begin
              if (err == ErrNone) err <= ErrVar;
            end else if (total >= TW'(MAX_CLAUSES)) begin
              if (err == ErrNone) err <= ErrFull;
            end else total <= total + TW'(1);
            if (s_axis_tlast) begin
              state <= StCheck; cur <= '0; side_q <= 1'b0;
            end
          end
        end
        StCheck: begin
          // cur steps clause indexes; side_q covers the registered clause read.
          if (side_q) begin
            if ((la >> 1) >= LW'(nvar) || (lb >> 1) >= LW'(nvar))
              if (err == ErrNone) err <= ErrVar;
          end
          if (cur < SW'(total)) begin
            cur <= cur + SW'(1); side_q <= 1'b1;
          end else if (!side_q || cur == SW'(total)) begin
            side_q <= 1'b0;
            if (!side_q) begin
              vis <= '0; rev <= 1'b0; k <= '0; olen <= '0; label <= '0;
              state <= (err == ErrNone) ? StRoot : StOut;
              sat <= 1'b0;
            end
            cur <= SW'(total) + SW'(1);
          end
        end
        StRoot: begin
          // Pick next root: forward scans k upward, reverse scans order downward.
          if (!rev) begin
            if (k == DW'(2 * nvar)) begin
              rev <= 1'b1; vis <= '0; k <= olen;
            end else begin
              if (!vis[k[LW-1:0]]) begin
                node <= k[LW-1:0]; vis[k[LW-1:0]] <= 1'b1;
                stk_node[0] <= k[LW-1:0]; depth <= DW'(1);
                cur <= '0; state <= StRd;
              end
              k <= k + DW'(1);
            end
          end else begin
            if (k == '0) begin
              k <= '0; state <= StCmp;
            end else state <= StRdWait;
          end
        end
        StRdWait: state <= StTop;
        StTop: begin
          k <= k - DW'(1);
          if (!vis[ford_rd]) begin
            node <= ford_rd; vis[ford_rd] <= 1'b1; lab[ford_rd] <= label + LW'(1);
            label <= label + LW'(1);
            stk_node[0] <= ford_rd; depth <= DW'(1); cur <= '0; state <= StRd;
          end else state <= StRoot;
        end
        StRd: begin
          side_q <= cur[0]; cur <= cur + SW'(1);
          state <= (cur < slots) ? StScan : StPop;
        end
        StScan: begin
          // crd holds the slot cur-1.
          if (hit && !vis[nbr]) begin
            vis[nbr] <= 1'b1;
            if (rev) lab[nbr] <= label;
            stk_cur[depth[LW-1:0] - LW'(1)] <= cur;
            stk_node[depth[LW-1:0]] <= nbr;
            depth <= depth + DW'(1); node <= nbr; cur <= '0; state <= StRd;
          end else if (cur < slots) begin
            side_q <= cur[0]; cur <= cur + SW'(1);
          end else state <= StPop;
        end
        StPop: begin
          if (!rev) begin ford[olen[LW-1:0]] <= node; olen <= olen + DW'(1); end
          depth <= depth - DW'(1);
          if (depth == DW'(1)) state <= StRoot;
          else state <= StPopRd;
        end
        StPopRd: state <= StPopTop;  // stack read settles
        StPopTop: begin
          node <= rd_node; cur <= rd_cur; state <= StRd;
        end
        StCmp: begin
          if (k == DW'(2 * nvar)) begin sat <= 1'b1; state <= StOut; end
          else state <= StCmpB;
        end
        StCmpB: begin
          if (!k[0]) lab_a <= lab_rd;
          else if (lab_a == lab_rd) begin sat <= 1'b0; state <= StOut; end
          if (!(k[0] && lab_a == lab_rd)) state <= StCmp;
          if (!(k[0] && lab_a == lab_rd)) k <= k + DW'(1);
          if (!k[0]) state <= StClr;
        end
        StClr: state <= StCmp;  // lab_rd for the odd literal settles
        StOut: begin
          if (!m_axis_tvalid) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= {5'd0, err, sat && (err == ErrNone)};
            total <= '0; err <= ErrNone; state <= StLoad;
          end
        end
        default: state <= StLoad;
      endcase
    end
  end
endmodule

@@ hdl/tsat_checker.sv @@
// Port-level checker for the 2-SAT solver, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"
module tsat_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic       s_axis_tlast,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata
);
  `CHK_NEXT(a_last_stalls, clk, rst, s_axis_tvalid && s_axis_tready && s_axis_tlast, !s_axis_tready)
  `CHK_IMPLY(a_no_in_with_out, clk, rst, m_axis_tvalid, !s_axis_tready)
  `CHK_IMPLY(a_err_no_sat, clk, rst, m_axis_tvalid && m_axis_tdata[2:1] != 2'd0, !m_axis_tdata[0])
  `CHK_IMPLY(a_err_range, clk, rst, m_axis_tvalid, m_axis_tdata[2:1] != 2'd3)
  `CHK_NEXT(a_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
endmodule

bind two_sat_scc_solver_top tsat_checker u_chk (.*);
